[rtl/uiap_pkg.sv]
`default_nettype none

package uiap_pkg;

    // List geometry
    localparam int DEPTH  = 128;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Beat field widths
    localparam int DATA_W = 32;
    localparam int POS_W  = 8;
    localparam int CNTO_W = 8;

    // Width used when comparing a position against the count
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Request modes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_DUP    = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    // Store access from the sequencer
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
    } t_mem_req;

    // Finished result
    typedef struct packed {
        t_status                  status;
        logic signed [DATA_W-1:0] read_value;
        logic [CNTO_W-1:0]        entry_count;
    } t_result;

endpackage

`default_nettype wire

[rtl/uiap_in_if.sv]
`default_nettype none

interface uiap_in_if;
    logic                               valid;
    logic                               ready;
    logic                               mode;
    logic signed [uiap_pkg::DATA_W-1:0] value;
    logic [uiap_pkg::POS_W-1:0]         position;

    modport source (output valid, output mode, output value, output position, input ready);
    modport sink   (input valid, input mode, input value, input position, output ready);
endinterface

`default_nettype wire

[rtl/uiap_out_if.sv]
`default_nettype none

interface uiap_out_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         status;
    logic signed [uiap_pkg::DATA_W-1:0] read_value;
    logic [uiap_pkg::CNTO_W-1:0]        entry_count;

    modport source (output valid, output status, output read_value, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input read_value, input entry_count,
                    output ready);
endinterface

`default_nettype wire

[rtl/unique_insert_at_position.sv]
`default_nettype none

// Channel   Dir  Fields                                  Handshake
// i_req     in   mode, value, position                   valid/ready
// o_rsp     out  status, read_value, entry_count         valid/ready
//
// One beat in, one beat out; one item in flight at a time.
// Read: store read, captured result, output register. Insert with count n at slot p,
// paced by the store's single read port: scan of all n entries (one scan read per cycle),
// then entries p..n-1 shift up (one shift move per cycle), then the write at slot p.
// Reset clears the count and control; store contents need no clearing.
// A result waits in the output register while the next request is taken.
module unique_insert_at_position (
    input  wire          i_clk,
    input  wire          i_rst_n,
    uiap_in_if.sink      i_req,
    uiap_out_if.source   o_rsp
);

    uiap_pkg::t_mem_req            mem_req;
    logic [uiap_pkg::DATA_W-1:0]   rd_data;
    logic                          res_valid;
    logic                          res_free;
    uiap_pkg::t_result             res;

    logic                          r_out_valid;
    uiap_pkg::t_result             r_out;

    uiap_store u_store (
        .i_clk     (i_clk),
        .i_mem     (mem_req),
        .o_rd_data (rd_data)
    );

    uiap_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_res_free  (res_free),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_mem       (mem_req),
        .i_rd_data   (rd_data)
    );

    // Output register
    assign res_free = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_free) begin
            r_out_valid <= res_valid;
        end
        if (res_free && res_valid) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out.status;
    assign o_rsp.read_value  = r_out.read_value;
    assign o_rsp.entry_count = r_out.entry_count;

endmodule

`default_nettype wire

[rtl/uiap_store.sv]
`default_nettype none

// Entry store: one write port, one read port, registered read data
module uiap_store (
    input  wire                               i_clk,
    input  wire uiap_pkg::t_mem_req           i_mem,
    output logic [uiap_pkg::DATA_W-1:0]       o_rd_data
);

    logic [uiap_pkg::DATA_W-1:0] mem [uiap_pkg::DEPTH];
    logic [uiap_pkg::DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_mem.wr_en) begin
            mem[i_mem.wr_addr] <= i_mem.wr_data;
        end
        if (i_mem.rd_en) begin
            r_rd_data <= mem[i_mem.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[rtl/uiap_seq.sv]
`default_nettype none

// Sequencer: checks, duplicate scan, shift-up pass and final write
module uiap_seq (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    uiap_in_if.sink                      i_req,
    input  wire                          i_res_free,
    output logic                         o_res_valid,
    output uiap_pkg::t_result            o_res,
    output uiap_pkg::t_mem_req           o_mem,
    input  wire [uiap_pkg::DATA_W-1:0]   i_rd_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_SHIFT,
        S_PUT,
        S_DONE
    } t_state;

    t_state                          r_state, n_state;
    logic [uiap_pkg::CNT_W-1:0]      r_count, n_count;
    logic [uiap_pkg::CNT_W-1:0]      r_idx, n_idx;
    logic [uiap_pkg::CNT_W-1:0]      r_pos, n_pos;
    logic [uiap_pkg::DATA_W-1:0]     r_value, n_value;
    logic [uiap_pkg::DATA_W-1:0]     r_rv, n_rv;
    uiap_pkg::t_status               r_status, n_status;

    logic [uiap_pkg::CMP_W-1:0]      pos_ext;
    logic [uiap_pkg::CMP_W-1:0]      cnt_ext;
    logic [uiap_pkg::CNT_W-1:0]      idx_m1;
    logic [uiap_pkg::CNT_W-1:0]      idx_m2;
    logic [uiap_pkg::CNT_W-1:0]      cnt_m1;

    assign pos_ext = uiap_pkg::CMP_W'(i_req.position);
    assign cnt_ext = uiap_pkg::CMP_W'(r_count);
    assign idx_m1  = r_idx - uiap_pkg::CNT_W'(1);
    assign idx_m2  = r_idx - uiap_pkg::CNT_W'(2);
    assign cnt_m1  = r_count - uiap_pkg::CNT_W'(1);

    // Next state and store access
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_value  = r_value;
        n_rv     = r_rv;
        n_status = r_status;
        o_mem    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_value = i_req.value;
                    n_pos   = pos_ext[uiap_pkg::CNT_W-1:0];
                    n_rv    = '0;
                    if (i_req.mode == uiap_pkg::MODE_READ) begin
                        if (pos_ext < cnt_ext) begin
                            o_mem.rd_en   = 1'b1;
                            o_mem.rd_addr = pos_ext[uiap_pkg::ADDR_W-1:0];
                            n_state       = S_READ;
                        end else begin
                            n_status = uiap_pkg::ST_BADPOS;
                            n_state  = S_DONE;
                        end
                    end else if (r_count == uiap_pkg::CNT_W'(uiap_pkg::DEPTH)) begin
                        n_status = uiap_pkg::ST_FULL;
                        n_state  = S_DONE;
                    end else if (pos_ext > cnt_ext) begin
                        n_status = uiap_pkg::ST_BADPOS;
                        n_state  = S_DONE;
                    end else if (r_count == '0) begin
                        n_state = S_PUT;
                    end else begin
                        // start scan at entry 0
                        o_mem.rd_en   = 1'b1;
                        o_mem.rd_addr = '0;
                        n_idx         = uiap_pkg::CNT_W'(1);
                        n_state       = S_SCAN;
                    end
                end
            end
            S_READ: begin
                n_rv     = i_rd_data;
                n_status = uiap_pkg::ST_OK;
                n_state  = S_DONE;
            end
            S_SCAN: begin
                // data for entry r_idx-1 is on the read port
                if (i_rd_data == r_value) begin
                    n_status = uiap_pkg::ST_DUP;
                    n_state  = S_DONE;
                end else if (r_idx == r_count) begin
                    if (r_pos == r_count) begin
                        n_state = S_PUT;
                    end else begin
                        o_mem.rd_en   = 1'b1;
                        o_mem.rd_addr = cnt_m1[uiap_pkg::ADDR_W-1:0];
                        n_idx         = r_count;
                        n_state       = S_SHIFT;
                    end
                end else begin
                    o_mem.rd_en   = 1'b1;
                    o_mem.rd_addr = r_idx[uiap_pkg::ADDR_W-1:0];
                    n_idx         = r_idx + uiap_pkg::CNT_W'(1);
                end
            end
            S_SHIFT: begin
                // entry r_idx-1 moves up to r_idx; read one below meanwhile
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = r_idx[uiap_pkg::ADDR_W-1:0];
                o_mem.wr_data = i_rd_data;
                if (idx_m1 == r_pos) begin
                    n_state = S_PUT;
                end else begin
                    o_mem.rd_en   = 1'b1;
                    o_mem.rd_addr = idx_m2[uiap_pkg::ADDR_W-1:0];
                    n_idx         = idx_m1;
                end
            end
            S_PUT: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = r_pos[uiap_pkg::ADDR_W-1:0];
                o_mem.wr_data = r_value;
                n_count       = r_count + uiap_pkg::CNT_W'(1);
                n_status      = uiap_pkg::ST_OK;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (i_res_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_value  <= n_value;
        r_rv     <= n_rv;
        r_status <= n_status;
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_res_valid       = (r_state == S_DONE);
    assign o_res.status      = r_status;
    assign o_res.read_value  = r_rv;
    assign o_res.entry_count = cnt_ext[uiap_pkg::CNTO_W-1:0];

endmodule

`default_nettype wire

[tb/tb_unique_insert_at_position.sv]
`default_nettype none

module tb_unique_insert_at_position;

    localparam int LIMIT_CYCLES = 1_500_000;
    localparam int TAIL_CYCLES  = 300;

    typedef struct packed {
        logic                               mode;
        logic signed [uiap_pkg::DATA_W-1:0] value;
        logic [uiap_pkg::POS_W-1:0]         position;
    } t_req_beat;

    logic clk;
    logic rst_n = 1'b0;

    uiap_in_if  req_if ();
    uiap_out_if rsp_if ();

    unique_insert_at_position dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Beats waiting to go out, and results still owed by the block
    t_req_beat          pending_q[$];
    uiap_pkg::t_result  owed_q[$];

    // Stimulus-side tracking: how many values the list should hold, and which
    int                                 gen_count;
    logic signed [uiap_pkg::DATA_W-1:0] used_vals[$];

    // Mirror of the list
    logic signed [uiap_pkg::DATA_W-1:0] list_mem [uiap_pkg::DEPTH];
    int                                 list_len;

    // Tallies for the summary
    int n_ins [4];
    int n_rd_ok, n_rd_bad, peak_len;

    int                 sent_n, got_n, cycle_n, errors;
    int                 hold_left;
    logic               hold_done;
    t_req_beat          acc_beat, next_beat;
    uiap_pkg::t_result  exp_r;
    logic               bad_beat;

    // Clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result of one request on the mirrored list; updates the mirror
    function automatic uiap_pkg::t_result list_apply(input t_req_beat b);
        uiap_pkg::t_result r;
        logic              dup;
        r.status     = uiap_pkg::ST_OK;
        r.read_value = '0;
        if (b.mode == uiap_pkg::MODE_INSERT) begin
            dup = 1'b0;
            if (list_len >= uiap_pkg::DEPTH) begin
                r.status = uiap_pkg::ST_FULL;
            end else if (int'(b.position) > list_len) begin
                r.status = uiap_pkg::ST_BADPOS;
            end else begin
                for (int i = 0; i < list_len; i++)
                    if (list_mem[i] == b.value) dup = 1'b1;
                if (dup) begin
                    r.status = uiap_pkg::ST_DUP;
                end else begin
                    for (int i = list_len; i > int'(b.position); i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[b.position] = b.value;
                    list_len++;
                    if (list_len > peak_len) peak_len = list_len;
                end
            end
            n_ins[r.status]++;
        end else if (int'(b.position) < list_len) begin
            r.read_value = list_mem[b.position];
            n_rd_ok++;
        end else begin
            r.status = uiap_pkg::ST_BADPOS;
            n_rd_bad++;
        end
        r.entry_count = list_len[uiap_pkg::CNTO_W-1:0];
        return r;
    endfunction

    // Queue one beat and keep the stimulus-side count in step
    task automatic queue_item(input logic m, input logic signed [uiap_pkg::DATA_W-1:0] v,
                              input logic [uiap_pkg::POS_W-1:0] p);
        t_req_beat b;
        logic      seen;
        b.mode     = m;
        b.value    = v;
        b.position = p;
        pending_q.push_back(b);
        seen = 1'b0;
        foreach (used_vals[i])
            if (used_vals[i] == v) seen = 1'b1;
        if (m == uiap_pkg::MODE_INSERT && gen_count < uiap_pkg::DEPTH &&
            int'(p) <= gen_count && !seen) begin
            used_vals.push_back(v);
            gen_count++;
        end
    endtask

    // One random beat; p_ok is the share (percent) of well-formed inserts
    task automatic gen_item(input int p_ok);
        int                                 r;
        logic signed [uiap_pkg::DATA_W-1:0] v;
        r = $urandom_range(0, 99);
        if (r < p_ok) begin
            case ($urandom_range(0, 7))
                0:       v = 32'sh7fffffff;
                1:       v = 32'sh80000000;
                2:       v = 32'sh00000000;
                3:       v = -32'sd1;
                default: v = $urandom;
            endcase
            queue_item(uiap_pkg::MODE_INSERT, v,
                       uiap_pkg::POS_W'($urandom_range(0, gen_count)));
        end else if (r < p_ok + 8) begin
            // repeat of a stored value
            v = (used_vals.size() != 0) ? used_vals[$urandom_range(0, used_vals.size() - 1)]
                                        : $urandom;
            queue_item(uiap_pkg::MODE_INSERT, v,
                       uiap_pkg::POS_W'($urandom_range(0, gen_count)));
        end else if (r < p_ok + 13) begin
            queue_item(uiap_pkg::MODE_INSERT, $urandom,
                       (gen_count < 255) ?
                           uiap_pkg::POS_W'($urandom_range(gen_count + 1, 255)) : 8'd255);
        end else if (r < p_ok + 18) begin
            queue_item(uiap_pkg::MODE_READ, $urandom,
                       uiap_pkg::POS_W'($urandom_range(gen_count, 255)));
        end else if (r < p_ok + 25) begin
            queue_item(1'($urandom_range(0, 1)), $urandom,
                       uiap_pkg::POS_W'($urandom_range(0, 255)));
        end else begin
            queue_item(uiap_pkg::MODE_READ, $urandom,
                       (gen_count > 0) ?
                           uiap_pkg::POS_W'($urandom_range(0, gen_count - 1)) : 8'd0);
        end
    endtask

    // Sender holds back until the block has nothing left to return
    task automatic wait_drained();
        do @(negedge clk);
        while (pending_q.size() != 0 || req_if.valid || owed_q.size() != 0);
    endtask

    // Driver: offers pending beats, records expectations on acceptance
    always @(posedge clk) begin
        if (!rst_n) begin
            req_if.valid    <= 1'b0;
            req_if.mode     <= uiap_pkg::MODE_INSERT;
            req_if.value    <= '0;
            req_if.position <= '0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                acc_beat.mode     = req_if.mode;
                acc_beat.value    = req_if.value;
                acc_beat.position = req_if.position;
                owed_q.push_back(list_apply(acc_beat));
                sent_n <= sent_n + 1;
            end
            if (!req_if.valid || req_if.ready) begin
                if (pending_q.size() != 0 &&
                    ((sent_n >= 500 && sent_n < 650) || $urandom_range(0, 99) >= 12)) begin
                    next_beat = pending_q.pop_front();
                    req_if.valid    <= 1'b1;
                    req_if.mode     <= next_beat.mode;
                    req_if.value    <= next_beat.value;
                    req_if.position <= next_beat.position;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, once, so the block backs up into its input
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && got_n >= 150) begin
            hold_left <= 600;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: checks each result beat against the oldest expectation
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                got_n <= got_n + 1;
                if (owed_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("Unexpected result: status %0d value %0d count %0d",
                                 rsp_if.status, rsp_if.read_value, rsp_if.entry_count);
                end else begin
                    exp_r    = owed_q.pop_front();
                    bad_beat = 1'b0;
                    if (rsp_if.status !== exp_r.status) bad_beat = 1'b1;
                    if (rsp_if.read_value !== exp_r.read_value) bad_beat = 1'b1;
                    if (rsp_if.entry_count !== exp_r.entry_count) bad_beat = 1'b1;
                    if (bad_beat) begin
                        errors++;
                        if (errors <= 10)
                            $display("Mismatch at result %0d: exp %0d/%0d/%0d got %0d/%0d/%0d",
                                     got_n, exp_r.status, exp_r.read_value,
                                     exp_r.entry_count, rsp_if.status,
                                     rsp_if.read_value, rsp_if.entry_count);
                    end
                end
            end
            if (hold_left != 0)
                rsp_if.ready <= 1'b0;
            else if (got_n >= 500 && got_n < 650)
                rsp_if.ready <= 1'b1;
            else
                rsp_if.ready <= ($urandom_range(0, 99) >= 12);
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_n <= cycle_n + 1;
        if (cycle_n > LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Sequence of the run
    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty list, edges of the fields, check precedence
        queue_item(uiap_pkg::MODE_READ,   32'sd0,         8'd0);
        queue_item(uiap_pkg::MODE_READ,   32'sd0,         8'd255);
        queue_item(uiap_pkg::MODE_INSERT, 32'sd5,         8'd1);
        queue_item(uiap_pkg::MODE_INSERT, 32'sh7fffffff,  8'd0);
        queue_item(uiap_pkg::MODE_INSERT, 32'sh80000000,  8'd1);
        queue_item(uiap_pkg::MODE_INSERT, 32'sd0,         8'd0);
        queue_item(uiap_pkg::MODE_INSERT, -32'sd1,        8'd2);
        queue_item(uiap_pkg::MODE_INSERT, 32'sh7fffffff,  8'd0);
        queue_item(uiap_pkg::MODE_INSERT, 32'sd123,       8'd255);
        queue_item(uiap_pkg::MODE_INSERT, 32'sh80000000,  8'd255);
        queue_item(uiap_pkg::MODE_INSERT, 32'sd0,         8'd4);
        queue_item(uiap_pkg::MODE_INSERT, 32'sh55555555,  8'd4);
        queue_item(uiap_pkg::MODE_INSERT, 32'shaaaaaaaa,  8'd6);
        queue_item(uiap_pkg::MODE_INSERT, 32'shaaaaaaaa,  8'd5);
        for (int i = 0; i < 6; i++)
            queue_item(uiap_pkg::MODE_READ, 32'shffffffff, i[uiap_pkg::POS_W-1:0]);
        queue_item(uiap_pkg::MODE_READ,   32'sd0,         8'd7);
        queue_item(uiap_pkg::MODE_READ,   32'sd0,         8'd128);
        wait_drained();

        // Short lists, with the receiver hold-off falling in here
        for (int i = 0; i < 300; i++) gen_item(20);
        wait_drained();

        // Longer lists
        for (int i = 0; i < 380; i++) gen_item(15);
        wait_drained();

        // Top up to full, then work against the full list
        while (gen_count < uiap_pkg::DEPTH) gen_item(70);
        for (int i = 0; i < 230; i++) gen_item(25);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (owed_q.size() != 0) errors++;
        $display("Covered %0d inserts: %0d stored, %0d duplicate, %0d bad slot, %0d list full",
                 n_ins[uiap_pkg::ST_OK] + n_ins[uiap_pkg::ST_BADPOS] +
                 n_ins[uiap_pkg::ST_DUP] + n_ins[uiap_pkg::ST_FULL],
                 n_ins[uiap_pkg::ST_OK], n_ins[uiap_pkg::ST_DUP],
                 n_ins[uiap_pkg::ST_BADPOS], n_ins[uiap_pkg::ST_FULL]);
        $display("and %0d reads (%0d out of range); longest list %0d, %0d mismatches",
                 n_rd_ok + n_rd_bad, n_rd_bad, peak_len, errors);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
